// ===== hw/rtl/vtp_pkg.sv =====
package vtp_pkg;

  localparam int FracBits = 16;

  // Radix-4 restoring division: two quotient bits per stage.
  localparam int DivStepBits = 2;
  localparam int DivSteps    = 32 / DivStepBits;
  localparam int DivLat      = DivSteps + 2;

  // Transform and projection front end, then the divider.
  localparam int FrontLat  = 10;
  localparam int PipeDepth = FrontLat + DivLat;

  // Width of coordinates inside the rotation stages.
  localparam int RotW = 34;

  localparam logic [47:0] ScaleReset = 48'h0100_0100_0100;
  localparam logic [63:0] XyCoeffReset =
    (64'd1 << (32 + FracBits)) | (64'd1 << FracBits);
  localparam logic [63:0] DepthCoeffReset = 64'd1 << (32 + FracBits);
  localparam logic signed [63:0] DepthHalf = 64'sd1 <<< (FracBits - 1);

  typedef enum logic [2:0] {
    RegAngles     = 3'd0,
    RegScale      = 3'd1,
    RegPosX       = 3'd2,
    RegPosY       = 3'd3,
    RegPosZ       = 3'd4,
    RegXyCoeff    = 3'd5,
    RegDepthCoeff = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t res;
    res.flag = 1'b0;
    res.val  = 32'(v);
    if (v > 66'sd2147483647) begin
      res.flag = 1'b1;
      res.val  = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      res.flag = 1'b1;
      res.val  = 32'sh8000_0000;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/vtp_sine_rom.sv =====
module vtp_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic        [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  localparam int IdxW = $clog2(DEPTH);
  localparam logic [63:0] QOne = 64'd1 << 30;

  typedef logic signed [31:0] rom_t [DEPTH];

  // Quarter-wave sine in Q1.30 by an odd Taylor polynomial of degree 15.
  function automatic logic [31:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    if (r >= 64'(DEPTH)) begin
      return 32'(QOne);
    end
    x  = (r * 64'd1686629713) / DEPTH;
    x2 = (x * x) >> 30;
    t  = QOne;
    t  = QOne - (((x2 * t) >> 30) / 64'd210);
    t  = QOne - (((x2 * t) >> 30) / 64'd156);
    t  = QOne - (((x2 * t) >> 30) / 64'd110);
    t  = QOne - (((x2 * t) >> 30) / 64'd72);
    t  = QOne - (((x2 * t) >> 30) / 64'd42);
    t  = QOne - (((x2 * t) >> 30) / 64'd20);
    t  = QOne - (((x2 * t) >> 30) / 64'd6);
    t  = (x * t) >> 30;
    if (t > QOne) begin
      t = QOne;
    end
    return t[31:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] r;
    logic [31:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      q4   = 64'(4 * i);
      quad = q4 / DEPTH;
      r    = q4 % DEPTH;
      v    = quad[0] ? quarter_sine(64'(DEPTH) - r) : quarter_sine(r);
      tab[i] = quad[1] ? -$signed(v) : $signed(v);
    end
    return tab;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [15:0]     cos_angle;
  logic [IdxW-1:0] sin_idx;
  logic [IdxW-1:0] cos_idx;

  // Cosine reads a quarter turn further on; the angle wraps at a full turn.
  assign cos_angle = angle_i + 16'd16384;
  assign sin_idx   = IdxW'((32'(angle_i) * DEPTH) >> 16);
  assign cos_idx   = IdxW'((32'(cos_angle) * DEPTH) >> 16);

  always_ff @(posedge clk_i) begin
    sin_o <= SineRom[sin_idx];
    cos_o <= SineRom[cos_idx];
  end

endmodule

// ===== hw/rtl/vtp_rotate.sv =====
module vtp_rotate (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [vtp_pkg::RotW-1:0]   a_i,
  input  logic signed [vtp_pkg::RotW-1:0]   b_i,
  input  logic signed [vtp_pkg::RotW-1:0]   c_i,
  input  logic signed [31:0]                sin_i,
  input  logic signed [31:0]                cos_i,
  output logic signed [vtp_pkg::RotW-1:0]   a_o,
  output logic signed [vtp_pkg::RotW-1:0]   b_o,
  output logic signed [vtp_pkg::RotW-1:0]   c_o
);
  import vtp_pkg::*;

  logic signed [65:0]     ac_q, bs_q, as_q, bc_q;
  logic signed [RotW-1:0] c_q;
  logic signed [65:0]     sum_a, sum_b;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= a_i * cos_i;
      bs_q <= b_i * sin_i;
      as_q <= a_i * sin_i;
      bc_q <= b_i * cos_i;
      c_q  <= c_i;
    end
  end

  // Round to nearest in Q1.30, ties towards plus infinity.
  assign sum_a = ac_q - bs_q + 66'sd536870912;
  assign sum_b = as_q + bc_q + 66'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= RotW'(sum_a >>> 30);
      b_o <= RotW'(sum_b >>> 30);
      c_o <= c_q;
    end
  end

endmodule

// ===== hw/rtl/vtp_divider.sv =====
module vtp_divider (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o,
  output logic               sat_o
);
  import vtp_pkg::*;

  logic [31:0] rem_q [DivSteps+1];
  logic [31:0] lo_q  [DivSteps+1];
  logic [31:0] dv_q  [DivSteps+1];
  logic        neg_q [DivSteps+1];
  logic        ovf_q [DivSteps+1];
  logic [31:0] rem_d [DivSteps+1];
  logic [31:0] lo_d  [DivSteps+1];

  logic [63:0] nmag;
  logic [31:0] dmag;

  assign nmag = num_i[63] ? 64'(-num_i) : 64'(num_i);
  assign dmag = den_i[31] ? 32'(-den_i) : 32'(den_i);

  // A quotient of 2^32 or more can only saturate, so the steps may ignore it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= nmag[63:32];
      lo_q[0]  <= nmag[31:0];
      dv_q[0]  <= dmag;
      neg_q[0] <= num_i[63] ^ den_i[31];
      ovf_q[0] <= nmag[63:32] >= dmag;
    end
  end

  assign rem_d[0] = rem_q[0];
  assign lo_d[0]  = lo_q[0];

  for (genvar j = 1; j <= DivSteps; j++) begin : g_step
    always_comb begin
      logic [32:0] r;
      logic [31:0] rem;
      logic [31:0] lo;
      rem = rem_q[j-1];
      lo  = lo_q[j-1];
      for (int k = 0; k < DivStepBits; k++) begin
        r  = {rem, lo[31]};
        lo = {lo[30:0], 1'b0};
        if (r >= {1'b0, dv_q[j-1]}) begin
          r     = r - {1'b0, dv_q[j-1]};
          lo[0] = 1'b1;
        end
        rem = r[31:0];
      end
      rem_d[j] = rem;
      lo_d[j]  = lo;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d[j];
        lo_q[j]  <= lo_d[j];
        dv_q[j]  <= dv_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  logic [31:0]        quo_mag;
  logic               over;
  logic signed [31:0] quo_val;

  assign quo_mag = lo_q[DivSteps];
  assign over    = ovf_q[DivSteps]
                 || (!neg_q[DivSteps] && quo_mag[31])
                 || (neg_q[DivSteps] && (quo_mag > 32'h8000_0000));

  always_comb begin
    if (over) begin
      quo_val = neg_q[DivSteps] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_q[DivSteps]) begin
      quo_val = $signed(32'(-quo_mag));
    end else begin
      quo_val = $signed(quo_mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_val;
      sat_o <= over;
    end
  end

  logic unused_rem;
  assign unused_rem = ^rem_d[DivSteps] ^ ^lo_d[0] ^ ^rem_d[0]
                    ^ ^rem_q[DivSteps] ^ ^dv_q[DivSteps];

endmodule

// ===== hw/rtl/vertex_transform_project.sv =====
// Vertex transform and perspective projection, one vertex per beat.
// Slave stream: one beat carries a model-space vertex x, y, z in signed
// Q16.16. Master stream: one beat carries the projected x, y and depth, with
// tuser set when any value was clamped to the 32-bit range.
// Registers are to be written through the plain write port while no vertex is
// in flight; the block does not enforce this. A new rotation angle goes
// through the registered sine lookup. Each beat passes an input register,
// rotation, scaling, translation and coefficient products, then a divider
// that yields two quotient bits per stage for x and y. The fully pipelined
// datapath takes one vertex per cycle unless the receiver stalls.
// When the receiver stalls, the whole pipeline holds, and tready on the
// slave side falls only while the last stage holds a beat that is not taken.
// Bubbles travel with their valid bits and are not squeezed out on a stall.
// Reset clears all valid bits and returns the registers to identity
// rotation, unit scale, zero position, unit coefficients and zero offset.
module vertex_transform_project #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // in_x, in_y, in_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // out_x, out_y, out_z
  output logic        m_axis_tuser_o,  // saturated
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import vtp_pkg::*;

  logic [47:0]        angles_q;
  logic [47:0]        scale_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [63:0]        xy_coeff_q;
  logic [63:0]        depth_coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angles_q      <= '0;
      scale_q       <= ScaleReset;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      pos_z_q       <= '0;
      xy_coeff_q    <= XyCoeffReset;
      depth_coeff_q <= DepthCoeffReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegAngles:     angles_q      <= cfg_data_i[47:0];
        RegScale:      scale_q       <= cfg_data_i[47:0];
        RegPosX:       pos_x_q       <= cfg_data_i[31:0];
        RegPosY:       pos_y_q       <= cfg_data_i[31:0];
        RegPosZ:       pos_z_q       <= cfg_data_i[31:0];
        RegXyCoeff:    xy_coeff_q    <= cfg_data_i;
        RegDepthCoeff: depth_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  vtp_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_x (
    .clk_i, .angle_i(angles_q[47:32]), .sin_o(sin_x), .cos_o(cos_x));
  vtp_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_y (
    .clk_i, .angle_i(angles_q[31:16]), .sin_o(sin_y), .cos_o(cos_y));
  vtp_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_z (
    .clk_i, .angle_i(angles_q[15:0]), .sin_o(sin_z), .cos_o(cos_z));

  // Global pipeline advance: everything moves unless the output beat waits.
  logic                 adv;
  logic [PipeDepth-1:0] valid_q;

  assign adv             = m_axis_tready_i || !valid_q[PipeDepth-1];
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = valid_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PipeDepth-2:0], s_axis_tvalid_i};
    end
  end

  logic signed [RotW-1:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= RotW'($signed(s_axis_tdata_i[31:0]));
      y0_q <= RotW'($signed(s_axis_tdata_i[63:32]));
      z0_q <= RotW'($signed(s_axis_tdata_i[95:64]));
    end
  end

  logic signed [RotW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

  vtp_rotate u_rot_x (
    .clk_i, .en_i(adv), .a_i(y0_q), .b_i(z0_q), .c_i(x0_q),
    .sin_i(sin_x), .cos_i(cos_x), .a_o(y1), .b_o(z1), .c_o(x1));
  vtp_rotate u_rot_y (
    .clk_i, .en_i(adv), .a_i(z1), .b_i(x1), .c_i(y1),
    .sin_i(sin_y), .cos_i(cos_y), .a_o(z2), .b_o(x2), .c_o(y2));
  vtp_rotate u_rot_z (
    .clk_i, .en_i(adv), .a_i(x2), .b_i(y2), .c_i(z2),
    .sin_i(sin_z), .cos_i(cos_z), .a_o(x3), .b_o(y3), .c_o(z3));

  logic signed [49:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= x3 * $signed(scale_q[47:32]);
      sy_q <= y3 * $signed(scale_q[31:16]);
      sz_q <= z3 * $signed(scale_q[15:0]);
    end
  end

  sat_t tx, ty, tz;

  assign tx = sat32(66'((sx_q + 50'sd128) >>> 8) + 66'(pos_x_q));
  assign ty = sat32(66'((sy_q + 50'sd128) >>> 8) + 66'(pos_y_q));
  assign tz = sat32(66'((sz_q + 50'sd128) >>> 8) + 66'(pos_z_q));

  logic signed [31:0] tx_q, ty_q, tz_q;
  logic               flag8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q    <= tx.val;
      ty_q    <= ty.val;
      tz_q    <= tz.val;
      flag8_q <= tx.flag | ty.flag | tz.flag;
    end
  end

  logic signed [31:0] dz;
  logic signed [63:0] numx_q, numy_q, pzp_q;
  logic signed [31:0] den_q;
  logic               flag9_q;

  // A depth of zero is taken as one LSB.
  assign dz = (tz_q == 32'sd0) ? 32'sd1 : tz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q  <= tx_q * $signed(xy_coeff_q[63:32]);
      numy_q  <= ty_q * $signed(xy_coeff_q[31:0]);
      pzp_q   <= dz * $signed(depth_coeff_q[63:32]);
      den_q   <= dz;
      flag9_q <= flag8_q;
    end
  end

  logic signed [31:0] qx, qy;
  logic               satx, saty;

  vtp_divider u_div_x (
    .clk_i, .en_i(adv), .num_i(numx_q), .den_i(den_q), .quo_o(qx), .sat_o(satx));
  vtp_divider u_div_y (
    .clk_i, .en_i(adv), .num_i(numy_q), .den_i(den_q), .quo_o(qy), .sat_o(saty));

  sat_t pz;
  sat_t dly_q [DivLat];

  assign pz = sat32(66'((pzp_q + DepthHalf) >>> FracBits)
                    - 66'($signed(depth_coeff_q[31:0])));

  // Depth and the earlier flags wait alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= '{flag: pz.flag | flag9_q, val: pz.val};
      for (int i = 1; i < DivLat; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign m_axis_tdata_o = {dly_q[DivLat-1].val, qy, qx};
  assign m_axis_tuser_o = dly_q[DivLat-1].flag | satx | saty;

  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output stage is empty");

  a_take_frees_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while the output beat is taken");

  a_hold_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(valid_q[PipeDepth-2:0]))
    else $error("pipeline moved during a stall");

endmodule

// ===== tb/vtp_checker.sv =====
module vtp_checker
  import vtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [95:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [95:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          clamped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RomDepth = 1024;
  localparam longint unsigned QOne = 64'd1 << 30;
  localparam longint unsigned HalfPi = 64'd1686629713;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } vertex_t;

  longint sine_q30 [RomDepth];
  vertex_t projected_q[$];

  logic [47:0] angles;
  logic [47:0] scales;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [63:0] xy_coeff;
  logic [63:0] depth_coeff;

  function automatic longint quarter_wave(input longint unsigned r);
    longint unsigned x, x2, t;
    if (r >= RomDepth) return QOne;
    x  = r * HalfPi / RomDepth;
    x2 = (x * x) >> 30;
    t  = QOne;
    for (int k = 7; k >= 1; k--)
      t = QOne - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
    t = (x * t) >> 30;
    if (t > QOne) t = QOne;
    return longint'(t);
  endfunction

  function automatic longint sine_at(input logic [15:0] ang);
    return sine_q30[(32'(ang) * RomDepth) >> 16];
  endfunction

  // a' = a*c - b*s, b' = a*s + b*c, rounded to nearest with ties upward.
  function automatic void turn(input longint a, b, input logic [15:0] ang,
                               output longint na, nb);
    longint s, c;
    s  = sine_at(ang);
    c  = sine_at(ang + 16'h4000);
    na = (a * c - b * s + (64'sd1 <<< 29)) >>> 30;
    nb = (a * s + b * c + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp32(input longint v, inout logic f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint scaled(input longint v, input logic [15:0] s);
    return (v * longint'($signed(s)) + 128) >>> 8;
  endfunction

  function automatic vertex_t project_vertex(input logic [95:0] d);
    longint x, y, z, t0, t1;
    longint cx, cy, cz, zoff;
    logic f;
    vertex_t r;
    f  = 1'b0;
    x  = longint'($signed(d[31:0]));
    y  = longint'($signed(d[63:32]));
    z  = longint'($signed(d[95:64]));
    cx = longint'($signed(xy_coeff[63:32]));
    cy = longint'($signed(xy_coeff[31:0]));
    cz = longint'($signed(depth_coeff[63:32]));
    zoff = longint'($signed(depth_coeff[31:0]));
    turn(y, z, angles[47:32], t0, t1);
    y = t0;
    z = t1;
    turn(z, x, angles[31:16], t0, t1);
    z = t0;
    x = t1;
    turn(x, y, angles[15:0], t0, t1);
    x = t0;
    y = t1;
    x = clamp32(scaled(x, scales[47:32]) + pos_x, f);
    y = clamp32(scaled(y, scales[31:16]) + pos_y, f);
    z = clamp32(scaled(z, scales[15:0]) + pos_z, f);
    if (z == 0) z = 1;
    r.x = 32'(clamp32((x * cx) / z, f));
    r.y = 32'(clamp32((y * cy) / z, f));
    r.z = 32'(clamp32(((z * cz + (64'sd1 <<< (FracBits - 1))) >>> FracBits) - zoff, f));
    r.sat = f;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    for (int i = 0; i < RomDepth; i++) begin
      longint v;
      int quad, r;
      quad = (4 * i) / RomDepth;
      r    = (4 * i) % RomDepth;
      v = (quad & 1) ? quarter_wave(RomDepth - r) : quarter_wave(r);
      sine_q30[i] = (quad & 2) ? -v : v;
    end
  end

  assign pending_o = projected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angles      <= '0;
      scales      <= ScaleReset;
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      xy_coeff    <= XyCoeffReset;
      depth_coeff <= DepthCoeffReset;
      errors_o    <= 0;
      checked_o   <= 0;
      clamped_o   <= 0;
      projected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAngles:     angles      <= cfg_data_i[47:0];
          RegScale:      scales      <= cfg_data_i[47:0];
          RegPosX:       pos_x       <= cfg_data_i[31:0];
          RegPosY:       pos_y       <= cfg_data_i[31:0];
          RegPosZ:       pos_z       <= cfg_data_i[31:0];
          RegXyCoeff:    xy_coeff    <= cfg_data_i;
          RegDepthCoeff: depth_coeff <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        projected_q.push_back(project_vertex(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (projected_q.size() == 0) begin
          report("unexpected beat", m_axis_tdata_i[31:0], '0);
        end else begin
          vertex_t w;
          w = projected_q.pop_front();
          if (m_axis_tdata_i[31:0] !== w.x) report("out_x", m_axis_tdata_i[31:0], w.x);
          if (m_axis_tdata_i[63:32] !== w.y) report("out_y", m_axis_tdata_i[63:32], w.y);
          if (m_axis_tdata_i[95:64] !== w.z) report("out_z", m_axis_tdata_i[95:64], w.z);
          if (m_axis_tuser_i !== w.sat) report("saturated", 32'(m_axis_tuser_i), 32'(w.sat));
          checked_o <= checked_o + 1;
          if (w.sat) clamped_o <= clamped_o + 1;
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import vtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that no register answers to; writes there must be ignored.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int Phases = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  int errors, pending, checked, clamped;
  int stall_mode = 0;
  int sent = 0;

  always #5 clk_i = ~clk_i;

  vertex_transform_project u_dut (.*);

  vtp_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .checked_o(checked), .clamped_o(clamped)
  );

  // The receiver's stall pattern changes from phase to phase.
  always @(posedge clk_i) begin
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 15) < 12) || ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_vertex(input logic [31:0] x, y, z, input int gap);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sent++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom) >>> $urandom_range(1, 30));
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom) >>> $urandom_range(6, 14));
    endcase
  endfunction

  function automatic logic [15:0] scale_pick();
    return ($urandom_range(0, 1) != 0) ? 16'($signed($urandom_range(0, 1024)) - 512)
                                       : 16'($urandom);
  endfunction

  task automatic configure(input int p);
    case (p)
      1: begin
        write_reg(RegAngles, 64'h0000_FFFF_FFFF_FFFF);
        write_reg(RegScale, 64'h7FFF_7FFF_7FFF);
        write_reg(RegPosX, 64'h7FFF_FFFF);
        write_reg(RegPosY, 64'h8000_0000);
        write_reg(RegPosZ, 64'h0);
        write_reg(RegXyCoeff, 64'h7FFF_FFFF_8000_0000);
        write_reg(RegDepthCoeff, 64'h7FFF_FFFF_8000_0000);
      end
      2: begin
        write_reg(RegAngles, 64'h4000_8000_C000);
        write_reg(RegScale, 64'h8000_8000_8000);
        write_reg(RegPosX, 64'hFFFF_0000);
        write_reg(RegPosY, 64'h0001_0000);
        write_reg(RegPosZ, 64'h0040_0000);
        write_reg(RegXyCoeff, 64'h8000_0000_7FFF_FFFF);
        write_reg(RegDepthCoeff, 64'h0001_0000_7FFF_FFFF);
      end
      Phases - 1: begin
        write_reg(RegAngles, 64'h0);
        write_reg(RegScale, 64'(ScaleReset));
        write_reg(RegPosX, 64'h0);
        write_reg(RegPosY, 64'h0);
        write_reg(RegPosZ, 64'h0);
        write_reg(RegXyCoeff, XyCoeffReset);
        write_reg(RegDepthCoeff, DepthCoeffReset);
        write_reg(RegUnused, {$urandom, $urandom});
      end
      default: begin
        write_reg(RegAngles, {$urandom, $urandom});
        write_reg(RegScale, {16'($urandom), scale_pick(), scale_pick(), scale_pick()});
        write_reg(RegPosX, {$urandom, coord()});
        write_reg(RegPosY, {$urandom, coord()});
        write_reg(RegPosZ, {$urandom, 32'($signed(coord()) >>> $urandom_range(0, 8))});
        write_reg(RegXyCoeff, {$urandom, $urandom});
        write_reg(RegDepthCoeff, {coord(), coord()});
      end
    endcase
    cfg_we_i <= 1'b0;
    // A fresh angle first has to pass through the registered sine lookup.
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed corners under the reset configuration.
    send_vertex(32'h0, 32'h0, 32'h0, 0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 2);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h0002_0000, 3);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0000, 0);
    drain();
    write_reg(RegAngles, 64'h4000_4000_4000);
    cfg_we_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0);
    send_vertex(32'h0, 32'h0, 32'h0, 0);

    for (int p = 1; p < Phases; p++) begin
      drain();
      configure(p);
      stall_mode = p % 4;
      for (int i = 0; i < 63; i++) begin
        int gap;
        // Bursts: mostly back to back, with occasional holes of random size.
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (p == 3 && i == 27) begin
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_vertex(coord(), coord(), coord(), gap);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    $display("Sent %0d vertices over %0d register settings; %0d results checked, %0d clamped.",
             sent, Phases, checked, clamped);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
